// ----- rtl/core/connection_table_with_credit_core_defines.svh -----
// ----------------------------------------------------------------------------
// connection table assertion macros
// shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted
// ----------------------------------------------------------------------------
`ifndef CONNECTION_TABLE_WITH_CREDIT_CORE_DEFINES_SVH
`define CONNECTION_TABLE_WITH_CREDIT_CORE_DEFINES_SVH

// condition that holds at every edge out of reset
`define CTWC_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define CTWC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CTWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/ctwc_pkg.sv -----
// ----------------------------------------------------------------------------
// ctwc_pkg
// types, codes and constants shared by the connection table blocks
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctwc_pkg;

  localparam int unsigned CAPACITY_DEF    = 64;
  localparam int unsigned ID_SPACE_DEF    = 1024;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam logic [30:0] INIT_WINDOW_RST = 31'd65536;

  localparam logic [2:0] STATE_FREE = 3'd0;
  localparam logic [2:0] STATE_OPEN = 3'd1;

  localparam logic signed [31:0] WIN_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] WIN_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    CMD_OPEN      = 3'd0,
    CMD_CLOSE     = 3'd1,
    CMD_SET_STATE = 3'd2,
    CMD_READ      = 3'd3,
    CMD_ADD       = 3'd4,
    CMD_SUB       = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_IN_USE = 2'd2,
    ST_RANGE  = 2'd3
  } status_e;

  // decoded command as it sits in the queue
  typedef struct packed {
    cmd_e               op;
    logic               bad;
    logic               by_slot;
    logic               id_ok;
    logic [9:0]         conn_id;
    logic [5:0]         slot_number;
    logic [2:0]         code;
    logic signed [31:0] amount;
  } cmd_t;

  // one table slot
  typedef struct packed {
    logic [9:0]         id;
    logic [2:0]         state;
    logic signed [31:0] window;
  } entry_t;

  typedef struct packed {
    status_e            status;
    logic [5:0]         slot;
    logic [9:0]         id;
    logic [2:0]         state;
    logic signed [31:0] window;
    logic [6:0]         count;
  } result_t;

  function automatic result_t err_result(status_e st, logic [6:0] cnt);
    result_t r;
    r        = '0;
    r.status = st;
    r.count  = cnt;
    return r;
  endfunction

endpackage

// ----- rtl/core/connection_table_with_credit_core.sv -----
// ----------------------------------------------------------------------------
// connection_table_with_credit_core
// dense connection table with id map and saturating credit windows
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_stall_o | command, by_slot, id, slot, code, amount
//  out     | output    | out_valid_o / out_stall_i | status, slot, id, state, window, count
//  cfg     | input     | cfg_valid_i / cfg_ready_o | initial window
//
//  set state, read, add and subtract pass lookup and execute in the back
//  end, open and any id or slot out of range end in lookup, close also
//  passes unmap, an unknown command ends in idle; lookup uses the
//  registered id map read, execute the registered slot store read.
//  after reset the id map is cleared one entry a cycle, all ID_SPACE
//  entries (1024 by default), with in_stall_o high throughout.
//  the queue holds two transactions; the back end starts a new transaction
//  only once the result register is free or being taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module connection_table_with_credit_core #(
  parameter int unsigned CAPACITY = ctwc_pkg::CAPACITY_DEF,
  parameter int unsigned ID_SPACE = ctwc_pkg::ID_SPACE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [30:0]        cfg_initial_window_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         command_i,
  input  logic               by_slot_i,
  input  logic [9:0]         conn_id_i,
  input  logic [5:0]         slot_number_i,
  input  logic [2:0]         new_state_code_i,
  input  logic signed [31:0] amount_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [5:0]         slot_out_o,
  output logic [9:0]         id_out_o,
  output logic [2:0]         state_out_o,
  output logic signed [31:0] window_out_o,
  output logic [6:0]         count_out_o
);
  import ctwc_pkg::*;

  logic    push, q_full, q_valid, q_pop, clearing;
  cmd_t    push_item, head_item;
  result_t res;

  ctwc_front #(
    .ID_SPACE (ID_SPACE)
  ) u_front (
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .by_slot_i        (by_slot_i),
    .conn_id_i        (conn_id_i),
    .slot_number_i    (slot_number_i),
    .new_state_code_i (new_state_code_i),
    .amount_i         (amount_i),
    .q_full_i         (q_full),
    .clearing_i       (clearing),
    .push_o           (push),
    .item_o           (push_item)
  );

  ctwc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  ctwc_back #(
    .CAPACITY (CAPACITY),
    .ID_SPACE (ID_SPACE)
  ) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_initial_window_i (cfg_initial_window_i),
    .q_valid_i            (q_valid),
    .q_item_i             (head_item),
    .q_pop_o              (q_pop),
    .clearing_o           (clearing),
    .res_valid_o          (out_valid_o),
    .res_stall_i          (out_stall_i),
    .res_o                (res)
  );

  assign status_o     = res.status;
  assign slot_out_o   = res.slot;
  assign id_out_o     = res.id;
  assign state_out_o  = res.state;
  assign window_out_o = res.window;
  assign count_out_o  = res.count;

endmodule

// ----- rtl/core/ctwc_front.sv -----
// ----------------------------------------------------------------------------
// ctwc_front
// input handshake and command decode ahead of the queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctwc_front #(
  parameter int unsigned ID_SPACE = ctwc_pkg::ID_SPACE_DEF
) (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         command_i,
  input  logic               by_slot_i,
  input  logic [9:0]         conn_id_i,
  input  logic [5:0]         slot_number_i,
  input  logic [2:0]         new_state_code_i,
  input  logic signed [31:0] amount_i,
  input  logic               q_full_i,
  input  logic               clearing_i,
  output logic               push_o,
  output ctwc_pkg::cmd_t     item_o
);
  import ctwc_pkg::*;

  assign in_stall_o = q_full_i || clearing_i;
  assign push_o     = in_valid_i && !in_stall_o;

  always_comb begin
    item_o             = '0;
    item_o.op          = CMD_READ;
    item_o.by_slot     = by_slot_i;
    item_o.conn_id     = conn_id_i;
    item_o.slot_number = slot_number_i;
    item_o.code        = new_state_code_i;
    item_o.amount      = amount_i;
    item_o.id_ok       = (32'(conn_id_i) < 32'(ID_SPACE));
    unique case (command_i)
      CMD_OPEN:      item_o.op = CMD_OPEN;
      CMD_CLOSE:     item_o.op = CMD_CLOSE;
      CMD_SET_STATE: item_o.op = CMD_SET_STATE;
      CMD_READ:      item_o.op = CMD_READ;
      CMD_ADD:       item_o.op = CMD_ADD;
      CMD_SUB:       item_o.op = CMD_SUB;
      default:       item_o.bad = 1'b1;
    endcase
  end

endmodule

// ----- rtl/core/ctwc_queue.sv -----
// ----------------------------------------------------------------------------
// ctwc_queue
// short fifo of decoded commands between front and back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctwc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ctwc_pkg::cmd_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ctwc_pkg::cmd_t item_o
);
  import ctwc_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FillW = $clog2(QUEUE_DEPTH + 1);

  cmd_t             buf_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d;
  logic [PtrW-1:0]  rd_q, rd_d;
  logic [FillW-1:0] fill_q, fill_d;

  assign full_o  = (fill_q == FillW'(QUEUE_DEPTH));
  assign valid_o = (fill_q != '0);
  assign item_o  = buf_q[rd_q];

  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    fill_d = fill_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= item_i;
    end
  end

endmodule

// ----- rtl/core/ctwc_back.sv -----
// ----------------------------------------------------------------------------
// ctwc_back
// executes commands against the slot store and the id map, holds the
// initial window register and the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "connection_table_with_credit_core_defines.svh"

module ctwc_back #(
  parameter int unsigned CAPACITY = ctwc_pkg::CAPACITY_DEF,
  parameter int unsigned ID_SPACE = ctwc_pkg::ID_SPACE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [30:0]       cfg_initial_window_i,
  input  logic              q_valid_i,
  input  ctwc_pkg::cmd_t    q_item_i,
  output logic              q_pop_o,
  output logic              clearing_o,
  output logic              res_valid_o,
  input  logic              res_stall_i,
  output ctwc_pkg::result_t res_o
);
  import ctwc_pkg::*;

  localparam int unsigned SlotW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned IdW   = $clog2(ID_SPACE);
  localparam int unsigned MapW  = SlotW + 1;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_LOOKUP = 5'b00100,
    S_EXEC   = 5'b01000,
    S_UNMAP  = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [IdW-1:0]   clr_q, clr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [30:0]      iw_q;
  cmd_t             cur_q;
  logic [SlotW-1:0] s_q, s_d;
  logic [SlotW-1:0] last_q, last_d;
  logic             out_valid_q;
  result_t          res_q, res_d;
  logic             res_load;
  logic             out_free;

  // id map: valid bit over slot number
  logic [MapW-1:0]  map_mem [ID_SPACE];
  logic             map_we;
  logic [IdW-1:0]   map_wa;
  logic [MapW-1:0]  map_wd;
  logic [IdW-1:0]   map_ra;
  logic [MapW-1:0]  map_rd_q;

  entry_t           slot_mem [CAPACITY];
  logic             slot_we;
  logic [SlotW-1:0] slot_wa;
  entry_t           slot_wd;
  logic [SlotW-1:0] ra_a, ra_b;
  entry_t           rd_a_q, rd_b_q;

  logic             map_hit;
  logic [SlotW-1:0] map_slot;
  logic [32:0]      wsum;
  logic signed [31:0] win_new;
  entry_t           upd;

  assign cfg_ready_o = 1'b1;
  assign clearing_o  = (state_q == S_CLEAR);
  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign q_pop_o     = (state_q == S_IDLE) && q_valid_i && out_free;
  assign out_free    = !out_valid_q || !res_stall_i;

  assign map_ra   = IdW'(q_item_i.conn_id);
  assign map_hit  = map_rd_q[MapW-1];
  assign map_slot = map_rd_q[SlotW-1:0];
  assign ra_a     = (state_q == S_LOOKUP) ? s_d : s_q;
  assign ra_b     = (state_q == S_LOOKUP) ? last_d : last_q;

  // saturating credit update on the slot read for this transaction
  always_comb begin
    if (cur_q.op == CMD_SUB) begin
      wsum = {rd_a_q.window[31], rd_a_q.window} - {cur_q.amount[31], cur_q.amount};
    end else begin
      wsum = {rd_a_q.window[31], rd_a_q.window} + {cur_q.amount[31], cur_q.amount};
    end
    if (wsum[32] != wsum[31]) begin
      win_new = wsum[32] ? WIN_MIN : WIN_MAX;
    end else begin
      win_new = wsum[31:0];
    end
  end

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    cnt_d    = cnt_q;
    s_d      = s_q;
    last_d   = last_q;
    res_load = 1'b0;
    res_d    = res_q;
    map_we   = 1'b0;
    map_wa   = IdW'(cur_q.conn_id);
    map_wd   = '0;
    slot_we  = 1'b0;
    slot_wa  = s_q;
    slot_wd  = rd_b_q;
    upd      = rd_a_q;
    unique case (state_q)
      S_CLEAR: begin
        map_we = 1'b1;
        map_wa = clr_q;
        clr_d  = clr_q + 1'b1;
        if (clr_q == IdW'(ID_SPACE - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_pop_o) begin
          if (q_item_i.bad) begin
            res_load = 1'b1;
            res_d    = err_result(ST_RANGE, 7'(cnt_q));
          end else begin
            state_d = S_LOOKUP;
          end
        end
      end
      S_LOOKUP: begin
        last_d = SlotW'(cnt_q - 1'b1);
        if (cur_q.op == CMD_OPEN) begin
          res_load = 1'b1;
          state_d  = S_IDLE;
          if (32'(cnt_q) >= 32'(CAPACITY)) begin
            res_d = err_result(ST_FULL, 7'(cnt_q));
          end else if (!cur_q.id_ok) begin
            res_d = err_result(ST_RANGE, 7'(cnt_q));
          end else if (map_hit) begin
            res_d = err_result(ST_IN_USE, 7'(cnt_q));
          end else begin
            slot_we        = 1'b1;
            slot_wa        = SlotW'(cnt_q);
            slot_wd.id     = cur_q.conn_id;
            slot_wd.state  = STATE_OPEN;
            slot_wd.window = $signed({1'b0, iw_q});
            map_we         = 1'b1;
            map_wd         = {1'b1, SlotW'(cnt_q)};
            cnt_d          = cnt_q + 1'b1;
            res_d.status   = ST_OK;
            res_d.slot     = 6'(cnt_q);
            res_d.id       = cur_q.conn_id;
            res_d.state    = STATE_OPEN;
            res_d.window   = $signed({1'b0, iw_q});
            res_d.count    = 7'(cnt_q + 1'b1);
          end
        end else if (cur_q.by_slot) begin
          if (32'(cur_q.slot_number) >= 32'(cnt_q)) begin
            res_load = 1'b1;
            res_d    = err_result(ST_RANGE, 7'(cnt_q));
            state_d  = S_IDLE;
          end else begin
            s_d     = SlotW'(cur_q.slot_number);
            state_d = S_EXEC;
          end
        end else begin
          if (!cur_q.id_ok || !map_hit || (32'(map_slot) >= 32'(cnt_q))) begin
            res_load = 1'b1;
            res_d    = err_result(ST_RANGE, 7'(cnt_q));
            state_d  = S_IDLE;
          end else begin
            s_d     = map_slot;
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        res_load     = 1'b1;
        state_d      = S_IDLE;
        res_d.status = ST_OK;
        res_d.slot   = 6'(s_q);
        res_d.id     = rd_a_q.id;
        unique case (cur_q.op)
          CMD_CLOSE: begin
            // drop the closed id, move the last entry into the hole
            map_we       = 1'b1;
            map_wa       = IdW'(rd_a_q.id);
            slot_we      = (s_q != last_q);
            cnt_d        = cnt_q - 1'b1;
            state_d      = S_UNMAP;
            upd.state    = STATE_FREE;
          end
          CMD_SET_STATE: begin
            upd.state = cur_q.code;
            slot_we   = 1'b1;
            slot_wd   = upd;
          end
          CMD_ADD, CMD_SUB: begin
            upd.window = win_new;
            slot_we    = 1'b1;
            slot_wd    = upd;
          end
          CMD_READ, CMD_OPEN: begin
            upd = rd_a_q;
          end
        endcase
        res_d.state  = upd.state;
        res_d.window = upd.window;
        res_d.count  = 7'(cnt_d);
      end
      S_UNMAP: begin
        // moved entry now lives in the freed slot
        if (s_q != last_q) begin
          map_we = 1'b1;
          map_wa = IdW'(rd_b_q.id);
          map_wd = {1'b1, s_q};
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      iw_q        <= INIT_WINDOW_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        iw_q <= cfg_initial_window_i;
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (!res_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_item_i;
    end
    s_q    <= s_d;
    last_q <= last_d;
    if (res_load) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    map_rd_q <= map_mem[map_ra];
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    rd_a_q <= slot_mem[ra_a];
    rd_b_q <= slot_mem[ra_b];
  end

  `CTWC_ASSERT_ALWAYS(a_cnt_bound, clk_i, rst_ni, 32'(cnt_q) <= 32'(CAPACITY), "open count above capacity")
  `CTWC_ASSERT_IMP(a_res_room, clk_i, rst_ni, res_load, !out_valid_q || !res_stall_i, "result overwrites a pending transaction")
  `CTWC_ASSERT_IMP(a_no_pop_clear, clk_i, rst_ni, state_q == S_CLEAR, !q_pop_o, "command taken during map clear")
  `CTWC_ASSERT_NEXT(a_close_seq, clk_i, rst_ni, (state_q == S_EXEC) && (cur_q.op == CMD_CLOSE), (state_q == S_UNMAP) && (cnt_q + 1'b1 == $past(cnt_q)), "close did not shrink the table")

endmodule
